FILE: rtl/core/amr_pkg.sv
// amr_pkg: shared types, codes and the control store of the addressing mode resolver
// holds the microprogram, the dispatch table and the index selection
// no dependencies
package amr_pkg;

	// sizes
	localparam int AMR_MEM_DEPTH = 65536;
	localparam int STEP_W = 5;

	// page arithmetic
	localparam logic [7:0]  PAGE_LAST = 8'hFF;
	localparam logic [15:0] PAGE_MASK = 16'hFF00;

	// request kinds
	localparam logic [1:0] KIND_WRITE        = 2'd0;
	localparam logic [1:0] KIND_READ         = 2'd1;
	localparam logic [1:0] KIND_RESOLVE      = 2'd2;
	localparam logic [1:0] KIND_RESOLVE_READ = 2'd3;

	// addressing modes
	localparam logic [3:0] MODE_ABS  = 4'd0;
	localparam logic [3:0] MODE_ABSX = 4'd1;
	localparam logic [3:0] MODE_ABSY = 4'd2;
	localparam logic [3:0] MODE_IMM  = 4'd3;
	localparam logic [3:0] MODE_IND  = 4'd4;
	localparam logic [3:0] MODE_INDX = 4'd5;
	localparam logic [3:0] MODE_INDY = 4'd6;
	localparam logic [3:0] MODE_REL  = 4'd7;
	localparam logic [3:0] MODE_ZP   = 4'd8;
	localparam logic [3:0] MODE_ZPX  = 4'd9;
	localparam logic [3:0] MODE_ZPY  = 4'd10;

	// control store addresses
	localparam logic [STEP_W-1:0] S_W0      = 5'd0;
	localparam logic [STEP_W-1:0] S_R0      = 5'd1;
	localparam logic [STEP_W-1:0] S_FIN     = 5'd2;
	localparam logic [STEP_W-1:0] S_DONE_RD = 5'd3;
	localparam logic [STEP_W-1:0] S_DONE    = 5'd4;
	localparam logic [STEP_W-1:0] S_A0      = 5'd5;
	localparam logic [STEP_W-1:0] S_A1      = 5'd6;
	localparam logic [STEP_W-1:0] S_A2      = 5'd7;
	localparam logic [STEP_W-1:0] S_I0      = 5'd8;
	localparam logic [STEP_W-1:0] S_N0      = 5'd9;
	localparam logic [STEP_W-1:0] S_N1      = 5'd10;
	localparam logic [STEP_W-1:0] S_N2      = 5'd11;
	localparam logic [STEP_W-1:0] S_N3      = 5'd12;
	localparam logic [STEP_W-1:0] S_N4      = 5'd13;
	localparam logic [STEP_W-1:0] S_X0      = 5'd14;
	localparam logic [STEP_W-1:0] S_X1      = 5'd15;
	localparam logic [STEP_W-1:0] S_X2      = 5'd16;
	localparam logic [STEP_W-1:0] S_X3      = 5'd17;
	localparam logic [STEP_W-1:0] S_X4      = 5'd18;
	localparam logic [STEP_W-1:0] S_Y0      = 5'd19;
	localparam logic [STEP_W-1:0] S_Y1      = 5'd20;
	localparam logic [STEP_W-1:0] S_Y2      = 5'd21;
	localparam logic [STEP_W-1:0] S_Y3      = 5'd22;
	localparam logic [STEP_W-1:0] S_Y4      = 5'd23;
	localparam logic [STEP_W-1:0] S_L0      = 5'd24;
	localparam logic [STEP_W-1:0] S_L1      = 5'd25;
	localparam logic [STEP_W-1:0] S_Z0      = 5'd26;
	localparam logic [STEP_W-1:0] S_Z1      = 5'd27;
	localparam logic [STEP_W-1:0] S_B0      = 5'd28;
	localparam logic [STEP_W-1:0] S_LAST    = S_B0;

	// effective address register operations
	typedef enum logic [2:0] {
		EA_HOLD = 3'd0,
		EA_BUS  = 3'd1,
		EA_WORD = 3'd2,
		EA_P1   = 3'd3,
		EA_ZP   = 3'd4,
		EA_REL  = 3'd5,
		EA_BAD  = 3'd6
	} ea_op_t;

	// memory address sources
	typedef enum logic [2:0] {
		ASEL_BUS    = 3'd0,
		ASEL_P1     = 3'd1,
		ASEL_P2     = 3'd2,
		ASEL_WORD   = 3'd3,
		ASEL_EA     = 3'd4,
		ASEL_EA_HI  = 3'd5,
		ASEL_EA_ZP1 = 3'd6
	} asel_t;

	// sequencing
	typedef enum logic [1:0] {
		NXT_SEQ    = 2'd0,
		NXT_JUMP   = 2'd1,
		NXT_BRANCH = 2'd2,
		NXT_DONE   = 2'd3
	} nxt_t;

	// datapath control from sequencer
	typedef struct packed {
		logic   load;
		ea_op_t ea_op;
		logic   tmp_ld;
		logic   use_idx;
		asel_t  asel;
		logic   we;
		logic   done;
		logic   data_rd;
	} dp_ctrl_t;

	// one control word
	typedef struct packed {
		ea_op_t              ea_op;
		logic                tmp_ld;
		logic                use_idx;
		asel_t               asel;
		logic                we;
		logic                data_rd;
		nxt_t                nxt;
		logic [STEP_W-1:0]   target;
	} uword_t;

	function automatic uword_t mk(ea_op_t e, logic t, logic u, asel_t a, logic w, logic d,
			nxt_t n, logic [STEP_W-1:0] tg);
		uword_t r;
		r.ea_op   = e;
		r.tmp_ld  = t;
		r.use_idx = u;
		r.asel    = a;
		r.we      = w;
		r.data_rd = d;
		r.nxt     = n;
		r.target  = tg;
		return r;
	endfunction

	// microprogram
	function automatic uword_t ucode(logic [STEP_W-1:0] s);
		uword_t r;
		case (s)
			// plain accesses
			S_W0:      r = mk(EA_BUS,  1'b0, 1'b0, ASEL_BUS,    1'b1, 1'b0, NXT_JUMP, S_DONE);
			S_R0:      r = mk(EA_BUS,  1'b0, 1'b0, ASEL_BUS,    1'b0, 1'b0, NXT_JUMP, S_DONE_RD);
			// common tail: optional read of the resolved byte
			S_FIN:     r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_BRANCH, S_DONE);
			S_DONE_RD: r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b1, NXT_DONE, S_DONE);
			S_DONE:    r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_DONE, S_DONE);
			// absolute and absolute indexed
			S_A0:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_P1,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_A1:      r = mk(EA_HOLD, 1'b1, 1'b0, ASEL_P2,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_A2:      r = mk(EA_WORD, 1'b0, 1'b1, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// immediate
			S_I0:      r = mk(EA_P1,   1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// indirect with page wrap of the pointer
			S_N0:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_P1,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_N1:      r = mk(EA_HOLD, 1'b1, 1'b0, ASEL_P2,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_N2:      r = mk(EA_WORD, 1'b0, 1'b0, ASEL_WORD,   1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_N3:      r = mk(EA_HOLD, 1'b1, 1'b0, ASEL_EA_HI,  1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_N4:      r = mk(EA_WORD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// zero page indexed indirect
			S_X0:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_P1,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_X1:      r = mk(EA_ZP,   1'b0, 1'b1, ASEL_EA,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_X2:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_X3:      r = mk(EA_HOLD, 1'b1, 1'b0, ASEL_EA_ZP1, 1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_X4:      r = mk(EA_WORD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// indirect indexed
			S_Y0:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_P1,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_Y1:      r = mk(EA_ZP,   1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_Y2:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_Y3:      r = mk(EA_HOLD, 1'b1, 1'b0, ASEL_EA_ZP1, 1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_Y4:      r = mk(EA_WORD, 1'b0, 1'b1, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// relative
			S_L0:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_P1,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_L1:      r = mk(EA_REL,  1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// zero page, plain and indexed
			S_Z0:      r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_P1,     1'b0, 1'b0, NXT_SEQ,  S_DONE);
			S_Z1:      r = mk(EA_ZP,   1'b0, 1'b1, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			// unknown mode
			S_B0:      r = mk(EA_BAD,  1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_FIN);
			default:   r = mk(EA_HOLD, 1'b0, 1'b0, ASEL_EA,     1'b0, 1'b0, NXT_JUMP, S_DONE);
		endcase
		return r;
	endfunction

	// dispatch table: first step of each program
	function automatic logic [STEP_W-1:0] entry_of(logic [1:0] kind, logic [3:0] mode);
		logic [STEP_W-1:0] r;
		case (kind)
			KIND_WRITE: r = S_W0;
			KIND_READ:  r = S_R0;
			default: begin
				case (mode)
					MODE_ABS, MODE_ABSX, MODE_ABSY: r = S_A0;
					MODE_IMM:                       r = S_I0;
					MODE_IND:                       r = S_N0;
					MODE_INDX:                      r = S_X0;
					MODE_INDY:                      r = S_Y0;
					MODE_REL:                       r = S_L0;
					MODE_ZP, MODE_ZPX, MODE_ZPY:    r = S_Z0;
					default:                        r = S_B0;
				endcase
			end
		endcase
		return r;
	endfunction

	// index register that a mode adds
	function automatic logic [7:0] idx_of(logic [3:0] mode, logic [7:0] x, logic [7:0] y);
		logic [7:0] r;
		case (mode)
			MODE_ABSX, MODE_INDX, MODE_ZPX: r = x;
			MODE_ABSY, MODE_INDY, MODE_ZPY: r = y;
			default:                        r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/addressing_mode_resolver_core.sv
// addressing_mode_resolver_core: 6502 addressing mode resolver with a byte store
// one request at a time, set by the memory reads in sequence through the single store port;
// the result strobe lasts one cycle and cannot be held off
// after reset busy stays high while the store is cleared
module addressing_mode_resolver_core import amr_pkg::*; #(
	parameter int MEM_DEPTH = AMR_MEM_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [3:0]  mode,
	input  logic [15:0] prog_counter,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [15:0] effective_address,
	output logic [7:0]  read_data,
	output logic        page_crossed,
	output logic        bad_mode
);

	dp_ctrl_t    ctrl;
	logic        mem_clearing;
	logic [15:0] mem_addr;
	logic [7:0]  mem_wdata;
	logic [7:0]  mem_rdata;

	// control sequencer
	amr_sequencer u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.mode         (mode),
		.mem_clearing (mem_clearing),
		.busy         (busy),
		.done         (done),
		.ctrl         (ctrl)
	);

	// address datapath
	amr_datapath u_dp (
		.clk               (clk),
		.ctrl              (ctrl),
		.mode              (mode),
		.prog_counter      (prog_counter),
		.index_x           (index_x),
		.index_y           (index_y),
		.bus_address       (bus_address),
		.write_data        (write_data),
		.rdata             (mem_rdata),
		.mem_addr          (mem_addr),
		.mem_wdata         (mem_wdata),
		.effective_address (effective_address),
		.read_data         (read_data),
		.page_crossed      (page_crossed),
		.bad_mode          (bad_mode)
	);

	// byte store
	amr_mem #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (mem_addr),
		.we       (ctrl.we),
		.wdata    (mem_wdata),
		.rdata    (mem_rdata),
		.clearing (mem_clearing)
	);

endmodule

FILE: rtl/core/amr_mem.sv
// amr_mem: byte store with one port, registered read, and a clearing pass after reset
// depends on amr_pkg for the default depth
module amr_mem import amr_pkg::*; #(
	parameter int MEM_DEPTH = AMR_MEM_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] addr,
	input  logic        we,
	input  logic [7:0]  wdata,
	output logic [7:0]  rdata,
	output logic        clearing
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

	logic [7:0]    mem [MEM_DEPTH];
	logic [AW-1:0] clr_cnt_q;
	logic          clearing_q;
	logic          in_range;
	logic          in_range_q;
	logic [7:0]    rdata_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	// addresses past the store read as zero and drop writes
	assign in_range = ({1'b0, addr} < 17'(MEM_DEPTH));

	// write port shared between the clearing pass and requests
	assign wr_en   = clearing_q | (we & in_range);
	assign wr_addr = clearing_q ? clr_cnt_q : addr[AW-1:0];
	assign wr_data = clearing_q ? 8'h00 : wdata;

	// clearing pass, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_cnt_q == LAST) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q    <= mem[addr[AW-1:0]];
		in_range_q <= in_range;
	end

	assign rdata    = in_range_q ? rdata_q : 8'h00;
	assign clearing = clearing_q;

`ifndef SYNTHESIS
	a_no_req_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !we)
		else $error("request write during clearing pass");
	a_clear_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_cnt_q) == LAST)
		else $error("clearing pass ended early");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing pass restarted");
`endif

endmodule

FILE: rtl/core/amr_datapath.sv
// amr_datapath: request registers, address arithmetic and result registers
// driven by the control word from amr_sequencer; depends on amr_pkg
module amr_datapath import amr_pkg::*; (
	input  logic        clk,
	input  dp_ctrl_t    ctrl,
	input  logic [3:0]  mode,
	input  logic [15:0] prog_counter,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  rdata,
	output logic [15:0] mem_addr,
	output logic [7:0]  mem_wdata,
	output logic [15:0] effective_address,
	output logic [7:0]  read_data,
	output logic        page_crossed,
	output logic        bad_mode
);

	logic [3:0]  mode_q;
	logic [15:0] pc_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [15:0] bus_q;
	logic [7:0]  wdata_q;
	logic [15:0] ea_q;
	logic [7:0]  tmp_q;
	logic        crossed_q;
	logic        bad_q;
	logic [15:0] ea_out_q;
	logic [7:0]  data_out_q;
	logic        crossed_out_q;
	logic        bad_out_q;

	logic [7:0]  idx;
	logic [15:0] word;
	logic [15:0] word_sum;
	logic [15:0] rel_sum;
	logic [15:0] pc_p1;
	logic [15:0] pc_p2;
	logic [15:0] ea_hi;

	// operand arithmetic
	assign idx      = ctrl.use_idx ? idx_of(mode_q, x_q, y_q) : 8'h00;
	assign word     = {rdata, tmp_q};
	assign word_sum = word + {8'h00, idx};
	assign rel_sum  = pc_q + {{8{rdata[7]}}, rdata};
	assign pc_p1    = pc_q + 16'd1;
	assign pc_p2    = pc_q + 16'd2;
	// pointer high byte stays in its page when the low byte is at the page end
	assign ea_hi    = (ea_q[7:0] == PAGE_LAST) ? (ea_q & PAGE_MASK) : (ea_q + 16'd1);

	// memory address select
	always_comb begin
		case (ctrl.asel)
			ASEL_BUS:    mem_addr = bus_q;
			ASEL_P1:     mem_addr = pc_p1;
			ASEL_P2:     mem_addr = pc_p2;
			ASEL_WORD:   mem_addr = word;
			ASEL_EA:     mem_addr = ea_q;
			ASEL_EA_HI:  mem_addr = ea_hi;
			ASEL_EA_ZP1: mem_addr = {8'h00, ea_q[7:0] + 8'd1};
			default:     mem_addr = ea_q;
		endcase
	end

	assign mem_wdata = wdata_q;

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mode_q  <= mode;
			pc_q    <= prog_counter;
			x_q     <= index_x;
			y_q     <= index_y;
			bus_q   <= bus_address;
			wdata_q <= write_data;
			bad_q   <= 1'b0;
		end else begin
			if (ctrl.tmp_ld) begin
				tmp_q <= rdata;
			end
			case (ctrl.ea_op)
				EA_HOLD: ;
				EA_BUS: begin
					ea_q      <= bus_q;
					crossed_q <= 1'b0;
				end
				EA_WORD: begin
					ea_q      <= word_sum;
					crossed_q <= ((word ^ word_sum) & PAGE_MASK) != 16'h0000;
				end
				EA_P1: begin
					ea_q      <= pc_p1;
					crossed_q <= 1'b0;
				end
				EA_ZP: begin
					ea_q      <= {8'h00, rdata + idx};
					crossed_q <= 1'b0;
				end
				EA_REL: begin
					ea_q      <= rel_sum;
					crossed_q <= ((pc_q ^ rel_sum) & PAGE_MASK) != 16'h0000;
				end
				EA_BAD: begin
					ea_q      <= 16'h0000;
					crossed_q <= 1'b0;
					bad_q     <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			ea_out_q      <= ea_q;
			data_out_q    <= ctrl.data_rd ? rdata : 8'h00;
			crossed_out_q <= crossed_q;
			bad_out_q     <= bad_q;
		end
	end

	assign effective_address = ea_out_q;
	assign read_data         = data_out_q;
	assign page_crossed      = crossed_out_q;
	assign bad_mode          = bad_out_q;

endmodule

FILE: rtl/core/amr_sequencer.sv
// amr_sequencer: step counter over the microprogram in amr_pkg, dispatch and jumps
// produces the datapath control word, busy and the result strobe
module amr_sequencer import amr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  logic [3:0] mode,
	input  logic       mem_clearing,
	output logic       busy,
	output logic       done,
	output dp_ctrl_t   ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	logic              running_q;
	logic              resolve_only_q;
	logic              done_q;
	logic              accept;
	uword_t            uw;

	assign busy   = running_q | mem_clearing;
	assign accept = start & ~busy;
	assign uw     = ucode(step_q);

	// control word to datapath: load on an accepted request, otherwise idle when no program runs
	always_comb begin
		ctrl.load    = accept;
		ctrl.ea_op   = running_q ? uw.ea_op : EA_HOLD;
		ctrl.tmp_ld  = running_q & uw.tmp_ld;
		ctrl.use_idx = uw.use_idx;
		ctrl.asel    = uw.asel;
		ctrl.we      = running_q & uw.we;
		ctrl.done    = running_q & (uw.nxt == NXT_DONE);
		ctrl.data_rd = uw.data_rd;
	end

	// next step
	always_comb begin
		case (uw.nxt)
			NXT_SEQ:    step_nxt = step_q + STEP_W'(1);
			NXT_JUMP:   step_nxt = uw.target;
			NXT_BRANCH: step_nxt = resolve_only_q ? uw.target : step_q + STEP_W'(1);
			NXT_DONE:   step_nxt = step_q;
			default:    step_nxt = step_q;
		endcase
	end

	// step counter and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= S_DONE;
			running_q      <= 1'b0;
			resolve_only_q <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= ctrl.done;
			if (accept) begin
				step_q         <= entry_of(kind, mode);
				running_q      <= 1'b1;
				resolve_only_q <= (kind == KIND_RESOLVE);
			end else if (running_q) begin
				if (uw.nxt == NXT_DONE) begin
					running_q <= 1'b0;
				end else begin
					step_q <= step_nxt;
				end
			end
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> running_q)
		else $error("accepted request did not start a program");
	a_done_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |=> done && !running_q)
		else $error("final step did not give one strobe");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> step_q <= S_LAST)
		else $error("step counter outside microprogram");
	a_no_run_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> !mem_clearing)
		else $error("program running during clearing pass");
`endif

endmodule

FILE: bench/addressing_mode_resolver_core_tb.sv
// addressing_mode_resolver_core_tb: self-checking bench for the 6502 addressing mode resolver
// keeps its own byte image and resolves every request to predict each result strobe
// depends on amr_pkg and addressing_mode_resolver_core
module addressing_mode_resolver_core_tb;
	import amr_pkg::*;

	localparam int         RANDOM_ITEMS   = 400;
	localparam int         QUIET_TAIL     = 80;
	localparam int         TAIL_CYCLES    = 12;
	localparam int         STALL_LIMIT    = 4 * AMR_MEM_DEPTH;
	localparam int         MAX_REPORTS    = 10;
	localparam logic [3:0] MODE_FIRST_BAD = MODE_ZPY + 4'd1;
	localparam logic [3:0] MODE_LAST_CODE = 4'hF;

	// one result as the block presents it
	typedef struct packed {
		logic [15:0] ea;
		logic [7:0]  data;
		logic        crossed;
		logic        bad;
	} resolve_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [3:0]  mode;
	logic [15:0] prog_counter;
	logic [7:0]  index_x;
	logic [7:0]  index_y;
	logic [15:0] bus_address;
	logic [7:0]  write_data;
	logic        done;
	logic [15:0] effective_address;
	logic [7:0]  read_data;
	logic        page_crossed;
	logic        bad_mode;

	// bench copy of the byte store, zero like the block after its clearing pass
	bit [7:0]        byte_image [AMR_MEM_DEPTH];
	resolve_result_t pending_results[$];

	int n_sent;
	int n_writes;
	int n_reads;
	int n_resolves;
	int n_bad_modes;
	int n_checked;
	int n_failures;
	int gap_pct;
	int stall_cycles;

	addressing_mode_resolver_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.kind              (kind),
		.mode              (mode),
		.prog_counter      (prog_counter),
		.index_x           (index_x),
		.index_y           (index_y),
		.bus_address       (bus_address),
		.write_data        (write_data),
		.done              (done),
		.effective_address (effective_address),
		.read_data         (read_data),
		.page_crossed      (page_crossed),
		.bad_mode          (bad_mode)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predictor: little-endian word from two byte addresses
	function automatic logic [15:0] fetch_word(logic [15:0] lo_addr, logic [15:0] hi_addr);
		return {byte_image[hi_addr], byte_image[lo_addr]};
	endfunction

	function automatic logic in_other_page(logic [15:0] a, logic [15:0] b);
		return ((a ^ b) & PAGE_MASK) != 16'h0000;
	endfunction

	// predictor: effective address of one addressing mode
	function automatic void resolve_address(input logic [3:0] m, input logic [15:0] pc,
			input logic [7:0] x, input logic [7:0] y, output logic [15:0] ea,
			output logic crossed, output logic bad);
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] base;
		logic [15:0] ptr;
		logic [7:0]  zp;
		logic [7:0]  op;
		p1      = pc + 16'd1;
		p2      = pc + 16'd2;
		op      = byte_image[p1];
		crossed = 1'b0;
		bad     = 1'b0;
		case (m)
			MODE_ABS: ea = fetch_word(p1, p2);
			MODE_ABSX, MODE_ABSY: begin
				base    = fetch_word(p1, p2);
				ea      = base + {8'h00, (m == MODE_ABSX) ? x : y};
				crossed = in_other_page(base, ea);
			end
			MODE_IMM: ea = p1;
			MODE_IND: begin
				// pointer high byte comes from the same page when the low byte is the last
				ptr = fetch_word(p1, p2);
				ea  = fetch_word(ptr, (ptr[7:0] == PAGE_LAST) ? (ptr & PAGE_MASK) : ptr + 16'd1);
			end
			MODE_INDX: begin
				zp = op + x;
				ea = fetch_word({8'h00, zp}, {8'h00, zp + 8'd1});
			end
			MODE_INDY: begin
				base    = fetch_word({8'h00, op}, {8'h00, op + 8'd1});
				ea      = base + {8'h00, y};
				crossed = in_other_page(base, ea);
			end
			MODE_REL: begin
				ea      = pc + {{8{op[7]}}, op};
				crossed = in_other_page(pc, ea);
			end
			MODE_ZP:  ea = {8'h00, op};
			MODE_ZPX: ea = {8'h00, op + x};
			MODE_ZPY: ea = {8'h00, op + y};
			default: begin
				ea  = 16'h0000;
				bad = 1'b1;
			end
		endcase
	endfunction

	// predictor: apply one accepted request and queue its result
	function automatic void predict_request(logic [1:0] k, logic [3:0] m, logic [15:0] pc,
			logic [7:0] x, logic [7:0] y, logic [15:0] bus, logic [7:0] wd);
		resolve_result_t r;
		r    = '0;
		r.ea = bus;
		case (k)
			KIND_WRITE: begin
				byte_image[bus] = wd;
				n_writes++;
			end
			KIND_READ: begin
				r.data = byte_image[bus];
				n_reads++;
			end
			default: begin
				resolve_address(m, pc, x, y, r.ea, r.crossed, r.bad);
				if (k == KIND_RESOLVE_READ)
					r.data = byte_image[r.ea];
				n_resolves++;
				if (r.bad)
					n_bad_modes++;
			end
		endcase
		pending_results.push_back(r);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// addresses biased towards page ends and the top of memory
	function automatic logic [15:0] pick_address();
		case ($urandom_range(0, 7))
			0:       return 16'hFFFF;
			1:       return {8'($urandom), 8'hFE + 8'($urandom_range(0, 1))};
			default: return 16'($urandom);
		endcase
	endfunction

	// send one request: optional idle burst, then hold start until accepted
	task automatic send_request(input logic [1:0] k, input logic [3:0] m,
			input logic [15:0] pc, input logic [7:0] x, input logic [7:0] y,
			input logic [15:0] bus, input logic [7:0] wd);
		int gap;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			gap = $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				start = 1'b0;
			end
		end
		@(negedge clk);
		kind         = k;
		mode         = m;
		prog_counter = pc;
		index_x      = x;
		index_y      = y;
		bus_address  = bus;
		write_data   = wd;
		start        = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_request(k, m, pc, x, y, bus, wd);
		n_sent++;
	endtask

	task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
		send_request(KIND_WRITE, 4'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			addr, data);
	endtask

	task automatic read_byte(input logic [15:0] addr);
		send_request(KIND_READ, 4'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			addr, 8'($urandom));
	endtask

	task automatic resolve_req(input logic [1:0] k, input logic [3:0] m,
			input logic [15:0] pc, input logic [7:0] x, input logic [7:0] y);
		send_request(k, m, pc, x, y, 16'($urandom), 8'($urandom));
	endtask

	// drop start and wait until every queued result has arrived
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// plain accesses at the ends of the address range, store cleared at reset
	task automatic test_plain_access();
		read_byte(16'h0000);
		read_byte(16'hFFFF);
		write_byte(16'hFFFF, 8'hFF);
		read_byte(16'hFFFF);
	endtask

	// every addressing mode at least once, with the page and zero page wrap corners
	task automatic test_mode_corners();
		write_byte(16'h1001, 8'hFF);
		write_byte(16'h1002, 8'h30);
		write_byte(16'h30FF, 8'h34);
		write_byte(16'h3000, 8'h12);
		write_byte(16'h3100, 8'h56);
		write_byte(16'h00FF, 8'h78);
		write_byte(16'h0000, 8'h9A);
		resolve_req(KIND_RESOLVE,      MODE_ABS,  16'h1000, 8'h00, 8'h00);
		resolve_req(KIND_RESOLVE_READ, MODE_ABSX, 16'h1000, 8'h01, 8'h00);
		resolve_req(KIND_RESOLVE,      MODE_ABSY, 16'h1000, 8'hFF, 8'h00);
		resolve_req(KIND_RESOLVE_READ, MODE_IMM,  16'h1000, 8'h00, 8'h00);
		// pointer low byte at the page end: high byte from the page start
		resolve_req(KIND_RESOLVE_READ, MODE_IND,  16'h1000, 8'h00, 8'h00);
		// zero page pointer at the last entry wraps to entry zero
		resolve_req(KIND_RESOLVE_READ, MODE_INDX, 16'h1000, 8'h00, 8'h00);
		resolve_req(KIND_RESOLVE,      MODE_INDY, 16'h1000, 8'h00, 8'hFF);
		// backward branch across a page
		resolve_req(KIND_RESOLVE,      MODE_REL,  16'h1000, 8'h00, 8'h00);
		resolve_req(KIND_RESOLVE_READ, MODE_ZP,   16'h1000, 8'h00, 8'h00);
		resolve_req(KIND_RESOLVE,      MODE_ZPX,  16'h1000, 8'h01, 8'h00);
		resolve_req(KIND_RESOLVE_READ, MODE_ZPY,  16'h1000, 8'h00, 8'hFF);
		// unknown modes give address zero
		resolve_req(KIND_RESOLVE_READ, MODE_FIRST_BAD, 16'h1000, 8'hFF, 8'hFF);
		resolve_req(KIND_RESOLVE,      MODE_LAST_CODE, 16'hFFFF, 8'hFF, 8'hFF);
		// operand fetch wraps past the top of memory
		resolve_req(KIND_RESOLVE_READ, MODE_ABS,  16'hFFFF, 8'h00, 8'h00);
	endtask

	// random programs: operand and pointer bytes written, then resolved, mixed with plain and random requests
	task automatic test_random_programs();
		int          first;
		int          sent_here;
		int          pick;
		bit          paused;
		logic [15:0] pc;
		logic [15:0] ptr;
		logic [7:0]  op_lo;
		logic [7:0]  op_hi;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  zp;
		logic [3:0]  m;
		first  = n_sent;
		paused = 1'b0;
		while (n_sent - first < RANDOM_ITEMS) begin
			sent_here = n_sent - first;
			// a quiet stretch in the middle and a quiet tail
			if (sent_here >= RANDOM_ITEMS - QUIET_TAIL || (sent_here >= 120 && sent_here < 180))
				gap_pct = 0;
			else
				gap_pct = 30;
			// sender holds off once until the block has returned everything
			if (!paused && sent_here >= 200) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				pc    = pick_address();
				op_lo = pick_byte();
				op_hi = pick_byte();
				x     = pick_byte();
				y     = pick_byte();
				m     = 4'($urandom_range(MODE_ABS, MODE_ZPY));
				write_byte(pc + 16'd1, op_lo);
				write_byte(pc + 16'd2, op_hi);
				case (m)
					MODE_IND: begin
						ptr = {op_hi, op_lo};
						write_byte(ptr, pick_byte());
						write_byte((ptr[7:0] == PAGE_LAST) ? (ptr & PAGE_MASK) : ptr + 16'd1,
							pick_byte());
					end
					MODE_INDX, MODE_INDY: begin
						zp = (m == MODE_INDX) ? op_lo + x : op_lo;
						write_byte({8'h00, zp}, pick_byte());
						write_byte({8'h00, zp + 8'd1}, pick_byte());
					end
					default: ;
				endcase
				resolve_req($urandom_range(0, 1) ? KIND_RESOLVE_READ : KIND_RESOLVE, m, pc, x, y);
			end else if (pick < 85) begin
				// plain traffic mostly kept to pages 00 and FF so reads find written bytes
				ptr = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom)};
				if ($urandom_range(0, 3) == 0)
					ptr = 16'($urandom);
				if ($urandom_range(0, 1))
					write_byte(ptr, pick_byte());
				else
					read_byte(ptr);
			end else begin
				send_request(2'($urandom), 4'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	// result check at each strobe against the oldest prediction
	always @(posedge clk) begin
		resolve_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				n_failures++;
				if (n_failures <= MAX_REPORTS)
					$display("unexpected result: ea %h data %h crossed %b bad %b",
						effective_address, read_data, page_crossed, bad_mode);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (effective_address !== want.ea || read_data !== want.data ||
						page_crossed !== want.crossed || bad_mode !== want.bad) begin
					n_failures++;
					if (n_failures <= MAX_REPORTS)
						$display("mismatch on result %0d: ea %h/%h data %h/%h crossed %b/%b bad %b/%b",
							n_checked, want.ea, effective_address, want.data, read_data,
							want.crossed, page_crossed, want.bad, bad_mode);
				end
			end
		end
	end

	// watchdog on cycles with neither a request nor a result accepted
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", stall_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_WRITE;
		mode         = MODE_ABS;
		prog_counter = 16'h0000;
		index_x      = 8'h00;
		index_y      = 8'h00;
		bus_address  = 16'h0000;
		write_data   = 8'h00;
		gap_pct      = 30;
		stall_cycles = 0;
		n_sent       = 0;
		n_writes     = 0;
		n_reads      = 0;
		n_resolves   = 0;
		n_bad_modes  = 0;
		n_checked    = 0;
		n_failures   = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_plain_access();
		test_mode_corners();
		test_random_programs();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d requests: %0d writes, %0d reads, %0d resolves (%0d unknown mode)",
			n_sent, n_writes, n_reads, n_resolves, n_bad_modes);
		$display("checked %0d results, %0d failures", n_checked, n_failures);
		if (n_failures == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
